// ===== hw/rtl/vos_pkg.sv =====
package vos_pkg;

  localparam int VOS_COARSE_SIZE = 32;
  localparam int VOS_MAX_SCALE   = 4;

  localparam int COORD_W   = 10;
  localparam int SCALE_W   = 4;
  localparam int CFG_W     = 6;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [7:0] LOW_BIT = 8'h01;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd2;
  localparam logic [1:0] REG_SCALE    = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_PLACE,
    OP_READ,
    OP_READ_BAD
  } op_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  local_x;
    logic [5:0]  local_y;
    logic [5:0]  local_z;
    logic [7:0]  voxel_value;
    logic [14:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       range_error;
  } out_beat_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [COORD_W-1:0] base_z;
    logic [SCALE_W-1:0] scale;
    logic [14:0]        read_index;
  } cmd_entry_t;

endpackage

// ===== hw/rtl/voxel_occupancy_scatter_top.sv =====
// Channel  Handshake              Beat
// in       in_push / in_full      in_beat (in_beat_t)
// out      out_pop / out_empty    out_beat (out_beat_t)
// cfg      cfg_wr_en              cfg_index, cfg_data
//
// A place beat with scale s is expanded into s*s*s fine voxels, one fine voxel per
// cycle through the read-modify-write of the two-port store; read, empty and scale-zero
// beats pass the expander as a single step. A result passes the address stage, the merge
// and write stage and the output queue before it shows on out_beat. After reset a clearing
// pass zeroes all COARSE_SIZE**3 cells (32768 by default) with in_full held high. A stalled
// result side fills the output queue and then the command queue before in_full rises.
module voxel_occupancy_scatter_top
  import vos_pkg::*;
#(
  parameter int COARSE_SIZE = VOS_COARSE_SIZE,
  parameter int MAX_SCALE   = VOS_MAX_SCALE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_push,
  input  in_beat_t         in_beat,
  output logic             in_full,
  input  logic             out_pop,
  output out_beat_t        out_beat,
  output logic             out_empty
);

  logic       q_push, q_full, q_pop, q_empty;
  cmd_entry_t q_entry, q_head;
  logic       clearing;
  logic       res_push, res_pop;
  out_beat_t  res_beat;

  assign res_pop = out_pop && !out_empty;

  vos_front #(
    .COARSE_SIZE(COARSE_SIZE),
    .MAX_SCALE  (MAX_SCALE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_beat  (in_beat),
    .in_full  (in_full),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  vos_fifo #(
    .ENTRY_T(cmd_entry_t),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  vos_back #(
    .COARSE_SIZE(COARSE_SIZE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res_pop (res_pop),
    .res_push(res_push),
    .res_beat(res_beat),
    .clearing(clearing)
  );

  vos_fifo #(
    .ENTRY_T(out_beat_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_beat),
    .full     (),
    .pop      (out_pop),
    .head     (out_beat),
    .empty    (out_empty)
  );

endmodule

// ===== hw/rtl/vos_fifo.sv =====
module vos_fifo #(
  parameter type ENTRY_T = logic,
  parameter int  DEPTH   = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  ENTRY_T push_data,
  output logic   full,
  input  logic   pop,
  output ENTRY_T head,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  ENTRY_T           slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/vos_front.sv =====
module vos_front
  import vos_pkg::*;
#(
  parameter int COARSE_SIZE = VOS_COARSE_SIZE,
  parameter int MAX_SCALE   = VOS_MAX_SCALE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_push,
  input  in_beat_t         in_beat,
  output logic             in_full,
  input  logic             q_full,
  input  logic             clearing,
  output logic             q_push,
  output cmd_entry_t       q_entry
);

  localparam int CELL_COUNT = COARSE_SIZE * COARSE_SIZE * COARSE_SIZE;

  logic [5:0]         origin_x_r, origin_y_r, origin_z_r;
  logic [2:0]         scale_r;
  logic [SCALE_W-1:0] scale_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      scale_r    <= 3'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_data[5:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_data[5:0];
        REG_ORIGIN_Z: origin_z_r <= cfg_data[5:0];
        REG_SCALE:    scale_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_full = q_full || clearing;
  assign q_push  = in_push && !in_full;

  always_comb begin
    scale_sat = (SCALE_W'(scale_r) > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                          : SCALE_W'(scale_r);
    q_entry.scale      = scale_sat;
    q_entry.read_index = in_beat.read_index;
    q_entry.base_x     = COORD_W'(origin_x_r) + COORD_W'(in_beat.local_x) * COORD_W'(scale_sat);
    q_entry.base_y     = COORD_W'(origin_y_r) + COORD_W'(in_beat.local_y) * COORD_W'(scale_sat);
    q_entry.base_z     = COORD_W'(origin_z_r) + COORD_W'(in_beat.local_z) * COORD_W'(scale_sat);
    if (in_beat.cmd == CMD_READ) begin
      q_entry.op = (32'(in_beat.read_index) < CELL_COUNT) ? OP_READ : OP_READ_BAD;
    end else if (in_beat.voxel_value == 8'd0 || scale_sat == '0) begin
      q_entry.op = OP_NOP;
    end else begin
      q_entry.op = OP_PLACE;
    end
  end

endmodule

// ===== hw/rtl/vos_back.sv =====
module vos_back
  import vos_pkg::*;
#(
  parameter int COARSE_SIZE = VOS_COARSE_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_entry_t q_head,
  output logic       q_pop,
  input  logic       res_pop,
  output logic       res_push,
  output out_beat_t  res_beat,
  output logic       clearing
);

  localparam int CELL_COUNT = COARSE_SIZE * COARSE_SIZE * COARSE_SIZE;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int RES_W      = $clog2(OUT_DEPTH + 1);
  localparam logic [COORD_W:0]  FINE_LIM     = (COORD_W + 1)'(2 * COARSE_SIZE);
  localparam logic [CELL_W-1:0] ROW_STRIDE   = CELL_W'(COARSE_SIZE);
  localparam logic [CELL_W-1:0] PLANE_STRIDE = CELL_W'(COARSE_SIZE * COARSE_SIZE);
  localparam logic [CELL_W-1:0] LAST_CELL    = CELL_W'(CELL_COUNT - 1);

  // Expander state.
  logic               busy_r, busy_nxt;
  cmd_entry_t         ent_r;
  logic [SCALE_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt, s_m1;
  logic               err_r, err_nxt;
  logic [RES_W-1:0]   reserved_r, reserved_nxt;
  logic               step_last, step_oor, step_err;
  logic [COORD_W-1:0] fx, fy, fz;

  // Address stage.
  logic               s1_vld_r, s1_last_r, s1_err_r, s1_oor_r;
  op_t                s1_op_r;
  logic [COORD_W-1:0] s1_fx_r, s1_fy_r, s1_fz_r;
  logic [14:0]        s1_ridx_r;
  logic [CELL_W-1:0]  s1_addr;
  logic [7:0]         s1_mask;
  logic               s1_wr;

  // Merge and write stage.
  logic               s2_vld_r, s2_last_r, s2_err_r, s2_read_r, s2_wr_r;
  logic [CELL_W-1:0]  s2_addr_r;
  logic [7:0]         s2_mask_r, mem_q_r, s2_base, s2_merged;
  logic               fwd_vld_r;
  logic [CELL_W-1:0]  fwd_addr_r;
  logic [7:0]         fwd_data_r;

  logic               clr_busy_r;
  logic [CELL_W-1:0]  clr_addr_r;
  logic               mem_we;
  logic [CELL_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic [7:0]         store_mem [CELL_COUNT];

  assign clearing = clr_busy_r;

  always_comb begin
    s_m1      = ent_r.scale - SCALE_W'(1);
    fx        = ent_r.base_x + COORD_W'(sx_r);
    fy        = ent_r.base_y + COORD_W'(sy_r);
    fz        = ent_r.base_z + COORD_W'(sz_r);
    step_oor  = ({1'b0, fx} >= FINE_LIM) || ({1'b0, fy} >= FINE_LIM) ||
                ({1'b0, fz} >= FINE_LIM);
    step_err  = err_r || (ent_r.op == OP_READ_BAD) ||
                ((ent_r.op == OP_PLACE) && step_oor);
    step_last = busy_r && ((ent_r.op != OP_PLACE) ||
                           (sx_r == s_m1 && sy_r == s_m1 && sz_r == s_m1));
    q_pop     = !q_empty && !clr_busy_r && (reserved_r < RES_W'(OUT_DEPTH)) &&
                (!busy_r || step_last);

    busy_nxt = busy_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sz_nxt   = sz_r;
    err_nxt  = err_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      sx_nxt   = '0;
      sy_nxt   = '0;
      sz_nxt   = '0;
      err_nxt  = 1'b0;
    end else if (step_last) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      err_nxt = step_err;
      if (sz_r != s_m1) begin
        sz_nxt = sz_r + 1'b1;
      end else begin
        sz_nxt = '0;
        if (sy_r != s_m1) begin
          sy_nxt = sy_r + 1'b1;
        end else begin
          sy_nxt = '0;
          sx_nxt = sx_r + 1'b1;
        end
      end
    end

    reserved_nxt = reserved_r;
    if (q_pop && !res_pop) begin
      reserved_nxt = reserved_r + 1'b1;
    end else if (res_pop && !q_pop) begin
      reserved_nxt = reserved_r - 1'b1;
    end
  end

  always_comb begin
    s1_wr   = (s1_op_r == OP_PLACE) && !s1_oor_r;
    s1_mask = s1_wr ? (LOW_BIT << {s1_fy_r[0], s1_fz_r[0], s1_fx_r[0]}) : 8'h00;
    if (s1_op_r == OP_READ) begin
      s1_addr = CELL_W'(s1_ridx_r);
    end else begin
      s1_addr = CELL_W'(s1_fx_r[COORD_W-1:1]) +
                CELL_W'(s1_fy_r[COORD_W-1:1]) * ROW_STRIDE +
                CELL_W'(s1_fz_r[COORD_W-1:1]) * PLANE_STRIDE;
    end
  end

  always_comb begin
    s2_base   = (fwd_vld_r && fwd_addr_r == s2_addr_r) ? fwd_data_r : mem_q_r;
    s2_merged = s2_base | s2_mask_r;
    res_push  = s2_vld_r && s2_last_r;
    res_beat.read_data   = s2_read_r ? s2_base : 8'h00;
    res_beat.range_error = s2_err_r;
    mem_we    = clr_busy_r || (s2_vld_r && s2_wr_r);
    mem_waddr = clr_busy_r ? clr_addr_r : s2_addr_r;
    mem_wdata = clr_busy_r ? 8'h00 : s2_merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      reserved_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      reserved_r <= reserved_nxt;
      s1_vld_r   <= busy_r;
      s2_vld_r   <= s1_vld_r;
      fwd_vld_r  <= s2_vld_r && s2_wr_r;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_CELL) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_head;
    end
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    sz_r       <= sz_nxt;
    err_r      <= err_nxt;
    s1_op_r    <= ent_r.op;
    s1_fx_r    <= fx;
    s1_fy_r    <= fy;
    s1_fz_r    <= fz;
    s1_oor_r   <= step_oor;
    s1_ridx_r  <= ent_r.read_index;
    s1_last_r  <= step_last;
    s1_err_r   <= step_err;
    s2_addr_r  <= s1_addr;
    s2_mask_r  <= s1_mask;
    s2_wr_r    <= s1_wr;
    s2_read_r  <= (s1_op_r == OP_READ);
    s2_last_r  <= s1_last_r;
    s2_err_r   <= s1_err_r;
    fwd_addr_r <= s2_addr_r;
    fwd_data_r <= s2_merged;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= store_mem[s1_addr];
  end

endmodule

// ===== dv/voxel_occupancy_scatter_top_tb.sv =====
module voxel_occupancy_scatter_top_tb;
  import vos_pkg::*;

  localparam int CELL_COUNT     = VOS_COARSE_SIZE * VOS_COARSE_SIZE * VOS_COARSE_SIZE;
  localparam int FINE_SPAN      = 2 * VOS_COARSE_SIZE;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 150000;
  localparam int PHASE_ITEMS    = 55;
  localparam int PRINT_LIMIT    = 50;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_push;
  in_beat_t         in_beat;
  logic             in_full;
  logic             out_pop;
  out_beat_t        out_beat;
  logic             out_empty;

  logic [7:0] occupancy_mirror [CELL_COUNT];
  logic [5:0] origin_x_reg;
  logic [5:0] origin_y_reg;
  logic [5:0] origin_z_reg;
  logic [2:0] scale_reg;
  out_beat_t  expected_beats [$];
  out_beat_t  want_beat;
  int         touched_cells [$];
  int         error_count = 0;
  int         idle_cycles = 0;
  bit         idle_on = 1'b1;
  bit         rx_hold_req = 1'b0;
  int         rx_gap;

  voxel_occupancy_scatter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_beat   (in_beat),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_beat  (out_beat),
    .out_empty (out_empty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int effective_scale();
    return (scale_reg > VOS_MAX_SCALE) ? VOS_MAX_SCALE : int'(scale_reg);
  endfunction

  // Mirrors the store update of one beat and returns the result it must produce.
  function automatic out_beat_t scatter_voxel(in_beat_t b);
    out_beat_t r;
    int        s;
    int        fx;
    int        fy;
    int        fz;
    int        cell_idx;
    int        bitpos;
    r = '0;
    if (b.cmd == CMD_READ) begin
      if (int'(b.read_index) < CELL_COUNT) begin
        r.read_data = occupancy_mirror[b.read_index];
      end else begin
        r.range_error = 1'b1;
      end
      return r;
    end
    if (b.voxel_value == 8'd0) return r;
    s = effective_scale();
    for (int sx = 0; sx < s; sx++) begin
      for (int sy = 0; sy < s; sy++) begin
        for (int sz = 0; sz < s; sz++) begin
          fx = int'(origin_x_reg) + int'(b.local_x) * s + sx;
          fy = int'(origin_y_reg) + int'(b.local_y) * s + sy;
          fz = int'(origin_z_reg) + int'(b.local_z) * s + sz;
          if (fx >= FINE_SPAN || fy >= FINE_SPAN || fz >= FINE_SPAN) begin
            r.range_error = 1'b1;
          end else begin
            cell_idx = (fx >> 1) + (fy >> 1) * VOS_COARSE_SIZE
                     + (fz >> 1) * VOS_COARSE_SIZE * VOS_COARSE_SIZE;
            bitpos = (fx & LOW_BIT) + 2 * (fz & LOW_BIT) + 4 * (fy & LOW_BIT);
            occupancy_mirror[cell_idx][bitpos] = 1'b1;
            touched_cells = {touched_cells, cell_idx};
            if (touched_cells.size() > 64) void'(touched_cells.pop_front());
          end
        end
      end
    end
    return r;
  endfunction

  function automatic in_beat_t make_place(int lx, int ly, int lz, int val);
    in_beat_t b;
    b.cmd         = CMD_PLACE;
    b.local_x     = 6'(lx);
    b.local_y     = 6'(ly);
    b.local_z     = 6'(lz);
    b.voxel_value = 8'(val);
    b.read_index  = 15'($urandom_range(0, CELL_COUNT - 1));
    return b;
  endfunction

  function automatic in_beat_t make_read(int idx);
    in_beat_t b;
    b.cmd         = CMD_READ;
    b.local_x     = 6'($urandom_range(0, 63));
    b.local_y     = 6'($urandom_range(0, 63));
    b.local_z     = 6'($urandom_range(0, 63));
    b.voxel_value = 8'($urandom_range(0, 255));
    b.read_index  = 15'(idx);
    return b;
  endfunction

  // Mostly picks coordinates that land inside the grid for the current origin and scale.
  function automatic logic [5:0] pick_local(logic [5:0] origin);
    int s;
    int span;
    s = effective_scale();
    if (s == 0 || $urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
    span = (FINE_SPAN - 1 - int'(origin)) / s;
    if (span > 63) span = 63;
    return 6'($urandom_range(0, span));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic send_beat(input in_beat_t b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_beat = b;
    do @(posedge clk); while (in_full);
    expected_beats = {expected_beats, scatter_voxel(b)};
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic send_random_item();
    in_beat_t b;
    int       pick;
    b = make_place(pick_local(origin_x_reg), pick_local(origin_y_reg),
                   pick_local(origin_z_reg), $urandom_range(1, 255));
    if ($urandom_range(0, 9) == 0) b.voxel_value = 8'd0;
    if ($urandom_range(0, 9) < 3) begin
      if (touched_cells.size() != 0 && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, touched_cells.size() - 1);
        b = make_read(touched_cells[pick]);
      end else begin
        b = make_read($urandom_range(0, CELL_COUNT - 1));
      end
    end
    send_beat(b);
  endtask

  task automatic wait_for_drain();
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_ORIGIN_X: origin_x_reg = 6'(data);
      REG_ORIGIN_Y: origin_y_reg = 6'(data);
      REG_ORIGIN_Z: origin_z_reg = 6'(data);
      REG_SCALE:    scale_reg    = 3'(data);
      default: ;
    endcase
  endtask

  task automatic set_placement(input int ox, input int oy, input int oz, input int sc);
    wait_for_drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SCALE, sc);
  endtask

  task automatic test_directed_corners();
    set_placement(0, 0, 0, 1);
    send_beat(make_place(0, 0, 0, 8'hFF));
    send_beat(make_place(1, 0, 0, 8'h80));
    send_beat(make_place(0, 1, 0, 8'h01));
    send_beat(make_place(0, 0, 1, 8'h01));
    send_beat(make_read(0));
    send_beat(make_place(63, 63, 63, 8'h01));
    send_beat(make_read(CELL_COUNT - 1));
    send_beat(make_place(5, 5, 5, 8'h00));
    send_beat(make_read(15'h2AAA));
    // The corner voxel straddles the far grid boundary.
    set_placement(63, 63, 63, 4);
    send_beat(make_place(0, 0, 0, 8'h3C));
    send_beat(make_place(63, 63, 63, 8'h01));
    send_beat(make_read(CELL_COUNT - 1));
    set_placement(0, 0, 0, 0);
    send_beat(make_place(3, 3, 3, 8'h55));
    send_beat(make_read(1 + VOS_COARSE_SIZE + VOS_COARSE_SIZE * VOS_COARSE_SIZE));
    // A scale above the maximum behaves as the maximum.
    set_placement(10, 20, 30, 7);
    send_beat(make_place(1, 1, 1, 8'hAA));
    send_beat(make_read(7 + 12 * VOS_COARSE_SIZE + 17 * VOS_COARSE_SIZE * VOS_COARSE_SIZE));
    set_placement(2, 4, 6, 5);
    send_beat(make_place(15, 14, 13, 8'hFE));
    send_beat(make_read(touched_cells[touched_cells.size() - 1]));
    set_placement(0, 0, 0, 2);
    send_beat(make_place(31, 31, 31, 8'h7F));
    send_beat(make_read(CELL_COUNT - 1));
  endtask

  task automatic test_random_placements();
    int ox;
    int oy;
    int oz;
    int sc;
    for (int phase = 0; phase < 6; phase++) begin
      ox = (phase == 1) ? 0 : (phase == 2) ? 63 : $urandom_range(0, 40);
      oy = (phase == 1) ? 0 : $urandom_range(0, 40);
      oz = (phase == 1) ? 0 : (phase == 4) ? 63 : $urandom_range(0, 40);
      case (phase)
        0: sc = 1;
        1: sc = 2;
        2: sc = 3;
        3: sc = 4;
        4: sc = 0;
        default: sc = $urandom_range(5, 7);
      endcase
      set_placement(ox, oy, oz, sc);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_for_drain();
        send_random_item();
      end
    end
  endtask

  task automatic test_result_backpressure();
    set_placement($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 30), 2);
    rx_hold_req = 1'b1;
    repeat (30) send_random_item();
  endtask

  task automatic test_streaming_no_gaps();
    set_placement($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63), 1);
    idle_on = 1'b0;
    repeat (60) send_random_item();
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_pop = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_pop = 1'b0;
        rx_gap = $urandom_range(1, 11);
        repeat (rx_gap - 1) @(negedge clk);
      end else begin
        out_pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with no expectation", int'(out_beat), 0);
      end else begin
        want_beat = expected_beats.pop_front();
        if (out_beat.read_data !== want_beat.read_data) begin
          report_mismatch("read_data", int'(out_beat.read_data), int'(want_beat.read_data));
        end
        if (out_beat.range_error !== want_beat.range_error) begin
          report_mismatch("range_error", int'(out_beat.range_error),
                          int'(want_beat.range_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("voxel_occupancy_scatter_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_ORIGIN_X;
    cfg_data     = '0;
    in_push      = 1'b0;
    in_beat      = '0;
    origin_x_reg = '0;
    origin_y_reg = '0;
    origin_z_reg = '0;
    scale_reg    = 3'd1;
    foreach (occupancy_mirror[i]) occupancy_mirror[i] = 8'h00;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed_corners();
    test_random_placements();
    test_result_backpressure();
    test_streaming_no_gaps();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("voxel_occupancy_scatter_top_tb: PASS");
    end else begin
      $display("voxel_occupancy_scatter_top_tb: FAIL");
    end
    $finish;
  end

endmodule
